@@ rtl/threshold_pedometer_step_length_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the step length block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_PEDOMETER_STEP_LENGTH_TOP_MACROS_SVH
`define THRESHOLD_PEDOMETER_STEP_LENGTH_TOP_MACROS_SVH

// Same-cycle implication.
`define TPSL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpsl: same-cycle check failed");

// Next-cycle implication.
`define TPSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpsl: next-cycle check failed");

`endif

@@ rtl/tpsl_pkg.sv @@
// ----------------------------------------------------------------------------
// tpsl_pkg
// Types and constants of the threshold pedometer with step length estimate.
// ----------------------------------------------------------------------------
package tpsl_pkg;

  localparam int unsigned InTdataW  = 24;  // magnitude, activity_class, pad
  localparam int unsigned OutTdataW = 72;  // step_seen, steps_total, length_total, pad
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [15:0] ThreshRst  = 16'd5016;
  localparam logic [7:0]  MinSmpRst  = 8'd10;
  localparam logic [2:0]  WalkLimRst = 3'd2;
  localparam logic [7:0]  GainRst    = 8'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_THRESHOLD   = 3'd0,
    CFG_MIN_SAMPLES      = 3'd1,
    CFG_WALK_CLASS_LIMIT = 3'd2,
    CFG_LENGTH_GAIN      = 3'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL_LO,
    ST_MUL_DEN,
    ST_MUL_NUM,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/threshold_pedometer_step_length_top.sv @@
// ----------------------------------------------------------------------------
// threshold_pedometer_step_length_top: step detector with step length total
// One sample at a time: UPDATE, then on a step MUL_LO, MUL_DEN, MUL_NUM, CHECK and DIV
// (DIV is bit-serial, skipped for a zero or saturated length), then EMIT, held on a stall.
// Reset: registers take defaults, trackers and totals clear at once.
// ----------------------------------------------------------------------------
module threshold_pedometer_step_length_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tpsl_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tpsl_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] magnitude, [18:16] activity_class, [23:19] zero
  input  logic [tpsl_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] step_seen, [32:1] steps_total, [64:33] length_total, [71:65] zero
  output logic [tpsl_pkg::OutTdataW-1:0]     m_axis_tdata
);

  tpsl_pkg::state_e state_q, state_d;

  logic [15:0] thresh_q;
  logic [7:0]  min_smp_q;
  logic [2:0]  walk_lim_q;
  logic [7:0]  gain_q;

  logic [15:0] mag_q;
  logic [2:0]  cls_q;

  logic [15:0] run_min_q, run_max_q, run_cnt_q;
  logic [31:0] run_sum_q;
  logic [31:0] step_cnt_q, len_acc_q;

  logic        step_q, flat_q, zero_q;
  logic [15:0] diff_q;
  logic [31:0] lo_q, den_q, rem_q, shreg_q;
  logic [4:0]  bit_cnt_q;

  logic                              out_valid_q;
  logic [tpsl_pkg::OutTdataW-1:0]    out_data_q;

  logic        in_req, emit_ok;
  logic [15:0] cnt_new, min_new, max_new;
  logic [32:0] sum_add;
  logic [31:0] sum_new;
  logic        step_hit;
  logic [31:0] mul_lo, mul_den;
  logic [39:0] mul_num;
  logic        sat_hit;
  logic [32:0] trial, trial_sub;
  logic        trial_ge;
  logic [31:0] step_cnt_new, len_acc_new;
  logic [32:0] len_add;

  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign emit_ok = !out_valid_q || m_axis_tready;

  // tracker update for the held sample
  assign cnt_new  = (run_cnt_q == 16'hFFFF) ? run_cnt_q : run_cnt_q + 16'd1;
  assign sum_add  = {1'b0, run_sum_q} + {17'd0, mag_q};
  assign sum_new  = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
  assign max_new  = (mag_q > run_max_q) ? mag_q : run_max_q;
  assign min_new  = (mag_q < run_min_q) ? mag_q : run_min_q;
  assign step_hit = (mag_q > thresh_q) && (cls_q <= walk_lim_q) &&
                    (cnt_new > {8'd0, min_smp_q});

  // one multiplier per state, each result registered
  assign mul_lo  = {16'd0, run_min_q} * {16'd0, run_cnt_q};
  assign mul_den = {16'd0, run_cnt_q} * {16'd0, diff_q};
  assign mul_num = {8'd0, shreg_q} * {32'd0, gain_q};

  // quotient overflows 32 bits when the upper numerator word reaches den
  assign sat_hit = (rem_q >= den_q);

  // restoring division, one quotient bit per cycle
  assign trial     = {rem_q, shreg_q[31]};
  assign trial_ge  = (trial >= {1'b0, den_q});
  assign trial_sub = trial - {1'b0, den_q};

  assign step_cnt_new = (step_cnt_q == 32'hFFFF_FFFF) ? step_cnt_q : step_cnt_q + 32'd1;
  assign len_add      = {1'b0, len_acc_q} + {1'b0, shreg_q};
  assign len_acc_new  = len_add[32] ? 32'hFFFF_FFFF : len_add[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpsl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      tpsl_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = tpsl_pkg::ST_UPDATE;
        end
      end
      tpsl_pkg::ST_UPDATE:  state_d = step_hit ? tpsl_pkg::ST_MUL_LO : tpsl_pkg::ST_EMIT;
      tpsl_pkg::ST_MUL_LO:  state_d = tpsl_pkg::ST_MUL_DEN;
      tpsl_pkg::ST_MUL_DEN: state_d = tpsl_pkg::ST_MUL_NUM;
      tpsl_pkg::ST_MUL_NUM: state_d = tpsl_pkg::ST_CHECK;
      tpsl_pkg::ST_CHECK: begin
        state_d = (zero_q || sat_hit) ? tpsl_pkg::ST_EMIT : tpsl_pkg::ST_DIV;
      end
      tpsl_pkg::ST_DIV: begin
        if (bit_cnt_q == 5'd31) begin
          state_d = tpsl_pkg::ST_EMIT;
        end
      end
      tpsl_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_d = tpsl_pkg::ST_IDLE;
        end
      end
      default: state_d = tpsl_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= tpsl_pkg::ThreshRst;
      min_smp_q  <= tpsl_pkg::MinSmpRst;
      walk_lim_q <= tpsl_pkg::WalkLimRst;
      gain_q     <= tpsl_pkg::GainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpsl_pkg::CFG_STEP_THRESHOLD:   thresh_q   <= cfg_data_i;
        tpsl_pkg::CFG_MIN_SAMPLES:      min_smp_q  <= cfg_data_i[7:0];
        tpsl_pkg::CFG_WALK_CLASS_LIMIT: walk_lim_q <= cfg_data_i[2:0];
        tpsl_pkg::CFG_LENGTH_GAIN:      gain_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // trackers, totals and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q   <= 16'hFFFF;
      run_max_q   <= 16'd0;
      run_sum_q   <= 32'd0;
      run_cnt_q   <= 16'd0;
      step_cnt_q  <= 32'd0;
      len_acc_q   <= 32'd0;
      step_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == tpsl_pkg::ST_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == tpsl_pkg::ST_UPDATE) begin
        run_cnt_q <= cnt_new;
        run_sum_q <= sum_new;
        run_max_q <= max_new;
        run_min_q <= min_new;
        step_q    <= step_hit;
      end
      if (state_q == tpsl_pkg::ST_EMIT && emit_ok) begin
        if (step_q) begin
          step_cnt_q <= step_cnt_new;
          len_acc_q  <= len_acc_new;
          run_min_q  <= 16'hFFFF;
          run_max_q  <= 16'd0;
          run_sum_q  <= 32'd0;
          run_cnt_q  <= 16'd0;
        end
      end
    end
  end

  // payload path
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      mag_q <= s_axis_tdata[15:0];
      cls_q <= s_axis_tdata[18:16];
    end
    unique case (state_q)
      tpsl_pkg::ST_MUL_LO: begin
        lo_q   <= mul_lo;
        flat_q <= (run_max_q <= run_min_q);
        diff_q <= run_max_q - run_min_q;
      end
      tpsl_pkg::ST_MUL_DEN: begin
        den_q   <= mul_den;
        zero_q  <= flat_q || (run_sum_q < lo_q);
        shreg_q <= run_sum_q - lo_q;
      end
      tpsl_pkg::ST_MUL_NUM: begin
        // numerator is (S - m*N) * K shifted up by 16: hold top word in rem
        rem_q   <= {8'd0, mul_num[39:16]};
        shreg_q <= {mul_num[15:0], 16'd0};
      end
      tpsl_pkg::ST_CHECK: begin
        bit_cnt_q <= 5'd0;
        if (zero_q) begin
          shreg_q <= 32'd0;
        end else if (sat_hit) begin
          shreg_q <= 32'hFFFF_FFFF;
        end
      end
      tpsl_pkg::ST_DIV: begin
        rem_q     <= trial_ge ? trial_sub[31:0] : trial[31:0];
        shreg_q   <= {shreg_q[30:0], trial_ge};
        bit_cnt_q <= bit_cnt_q + 5'd1;
      end
      tpsl_pkg::ST_EMIT: begin
        if (emit_ok) begin
          out_data_q <= {7'd0,
                         (step_q ? len_acc_new : len_acc_q),
                         (step_q ? step_cnt_new : step_cnt_q),
                         step_q};
        end
      end
      tpsl_pkg::ST_IDLE, tpsl_pkg::ST_UPDATE: ;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/tpsl_checker.sv @@
// ----------------------------------------------------------------------------
// tpsl_checker
// Port-level checks on the step length block, bound to its top level.
// ----------------------------------------------------------------------------
`include "threshold_pedometer_step_length_top_macros.svh"

module tpsl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tpsl_pkg::OutTdataW-1:0]   m_axis_tdata
);

  // a stalled result holds
  `TPSL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one sample at a time: busy right after a request
  `TPSL_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a result only comes out of the busy phase
  `TPSL_ASSERT_SAME(a_out_from_work, $rose(m_axis_tvalid), !$past(s_axis_tready))

  // a reported step means the step total is at least one
  `TPSL_ASSERT_SAME(a_step_count, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[32:1] != 32'd0)

endmodule

bind threshold_pedometer_step_length_top tpsl_checker u_tpsl_checker (.*);

@@ tb/threshold_pedometer_step_length_top_tb.sv @@
// ----------------------------------------------------------------------------
// threshold_pedometer_step_length_top_tb: self-checking bench for the pedometer
// Streams magnitude/class samples into the block and scores every result
// against a cycle-free model of the trackers, step test and length total.
// The run starts with a table of directed samples. Random phases follow, each
// with its own register setting. A phase of two-sample windows at full gain
// then grows the length total fast. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module threshold_pedometer_step_length_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic        step_seen;
    logic [31:0] steps_total;
    logic [31:0] length_total;
  } step_result_t;

  typedef struct packed {
    logic [15:0]  mag;
    logic [2:0]   cls;
    logic         typed;
    step_result_t want;
  } sample_row_t;

  localparam step_result_t NoStepYet = '0;

  // Reset setting: threshold 5016, more than 10 samples, classes 0..2 walk.
  localparam sample_row_t DirectedRows [22] = '{
    '{16'd0,     3'd0, 1'b1, NoStepYet},
    '{16'd65535, 3'd0, 1'b1, NoStepYet},
    '{16'd65535, 3'd7, 1'b1, NoStepYet},
    '{16'd5016,  3'd2, 1'b1, NoStepYet},
    '{16'd5017,  3'd3, 1'b1, NoStepYet},
    '{16'd1,     3'd5, 1'b1, NoStepYet},
    '{16'd32768, 3'd1, 1'b1, NoStepYet},
    '{16'h5555,  3'd6, 1'b1, NoStepYet},
    '{16'haaaa,  3'd4, 1'b1, NoStepYet},
    // count equals min_samples: still no step
    '{16'd5017,  3'd0, 1'b1, NoStepYet},
    '{16'd65535, 3'd2, 1'b0, NoStepYet},
    '{16'd6000,  3'd0, 1'b0, NoStepYet},
    '{16'd6000,  3'd1, 1'b0, NoStepYet},
    '{16'd6000,  3'd2, 1'b0, NoStepYet},
    '{16'd6000,  3'd3, 1'b0, NoStepYet},
    '{16'd6000,  3'd4, 1'b0, NoStepYet},
    '{16'd6000,  3'd5, 1'b0, NoStepYet},
    '{16'd6000,  3'd6, 1'b0, NoStepYet},
    '{16'd6000,  3'd7, 1'b0, NoStepYet},
    '{16'd6000,  3'd0, 1'b0, NoStepYet},
    '{16'd6000,  3'd1, 1'b0, NoStepYet},
    // flat window: max equals min, step adds no length
    '{16'd6000,  3'd1, 1'b0, NoStepYet}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [tpsl_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [tpsl_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  // [15:0] magnitude, [18:16] activity_class, [23:19] zero
  logic [tpsl_pkg::InTdataW-1:0]  s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  // [0] step_seen, [32:1] steps_total, [64:33] length_total, [71:65] zero
  logic [tpsl_pkg::OutTdataW-1:0] m_axis_tdata;

  // Register shadow
  logic [15:0] cfg_threshold;
  logic [7:0]  cfg_min_samples;
  logic [2:0]  cfg_walk_limit;
  logic [7:0]  cfg_gain;

  // Tracker and total shadow
  logic [15:0] trk_min;
  logic [15:0] trk_max;
  logic [31:0] trk_sum;
  logic [15:0] trk_count;
  logic [31:0] pred_steps;
  logic [31:0] length_sum;

  step_result_t due_results [$];
  logic         drv_typed;
  step_result_t drv_typed_res;
  bit           pace_gaps;
  int unsigned  samples_sent;
  int unsigned  results_seen;
  int unsigned  mismatches;
  int unsigned  cycle_cnt;

  threshold_pedometer_step_length_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1ns clk_i = 1'b1;
    #1ns clk_i = 1'b0;
  end

  function automatic void clear_trackers();
    trk_min   = 16'hffff;
    trk_max   = '0;
    trk_sum   = '0;
    trk_count = '0;
  endfunction

  function automatic logic [31:0] length_step();
    logic [63:0] lo;
    logic [63:0] diff;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    if (trk_max <= trk_min || trk_count == 16'd0) return '0;
    lo = {48'd0, trk_min} * {48'd0, trk_count};
    if ({32'd0, trk_sum} < lo) return '0;
    diff = {32'd0, trk_sum} - lo;
    num  = (diff * {56'd0, cfg_gain}) << 16;
    den  = {48'd0, trk_count} * {48'd0, trk_max - trk_min};
    q    = num / den;
    return (q > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : q[31:0];
  endfunction

  function automatic step_result_t track_sample(logic [15:0] mag, logic [2:0] cls);
    step_result_t res;
    logic [32:0]  wide;
    logic [31:0]  inc;
    if (trk_count != 16'hffff) trk_count++;
    wide    = {1'b0, trk_sum} + {17'd0, mag};
    trk_sum = wide[32] ? 32'hffff_ffff : wide[31:0];
    if (mag > trk_max) trk_max = mag;
    if (mag < trk_min) trk_min = mag;
    res.step_seen = 1'b0;
    if (mag > cfg_threshold && cls <= cfg_walk_limit && trk_count > {8'd0, cfg_min_samples}) begin
      inc = length_step();
      res.step_seen = 1'b1;
      if (pred_steps != 32'hffff_ffff) pred_steps++;
      wide       = {1'b0, length_sum} + {1'b0, inc};
      length_sum = wide[32] ? 32'hffff_ffff : wide[31:0];
      clear_trackers();
    end
    res.steps_total  = pred_steps;
    res.length_total = length_sum;
    return res;
  endfunction

  // Mostly back to back, sometimes a short or a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!pace_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Predict at the accepting edge of each request.
  always @(posedge clk_i) begin : sample_tap
    step_result_t pred;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pred = track_sample(s_axis_tdata[15:0], s_axis_tdata[18:16]);
      due_results.push_back(drv_typed ? drv_typed_res : pred);
    end
  end

  always @(posedge clk_i) begin : result_tap
    step_result_t got;
    step_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.step_seen    = m_axis_tdata[0];
      got.steps_total  = m_axis_tdata[32:1];
      got.length_total = m_axis_tdata[64:33];
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: step_seen %0d steps_total %0d length_total %0d",
                   got.step_seen, got.steps_total, got.length_total);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("mismatch at result %0d: step_seen exp %0d got %0d,",
                     results_seen, want.step_seen, got.step_seen);
            $display("  steps_total exp %0d got %0d, length_total exp %0d got %0d",
                     want.steps_total, got.steps_total, want.length_total,
                     got.length_total);
          end
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold - 1) @(posedge clk_i);
    end
  end

  // Hold valid high when the next request follows without a gap.
  task automatic send_sample(input logic [15:0] mag, input logic [2:0] cls,
                             input logic typed, input step_result_t typed_res);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, cls, mag};
    drv_typed     <= typed;
    drv_typed_res <= typed_res;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_seen != samples_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(input tpsl_pkg::cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      tpsl_pkg::CFG_STEP_THRESHOLD:   cfg_threshold   = value;
      tpsl_pkg::CFG_MIN_SAMPLES:      cfg_min_samples = value[7:0];
      tpsl_pkg::CFG_WALK_CLASS_LIMIT: cfg_walk_limit  = value[2:0];
      tpsl_pkg::CFG_LENGTH_GAIN:      cfg_gain        = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] thresh, input logic [7:0] min_smp,
                            input logic [2:0] walk, input logic [7:0] gain);
    settle();
    write_reg(tpsl_pkg::CFG_STEP_THRESHOLD, thresh);
    write_reg(tpsl_pkg::CFG_MIN_SAMPLES, {8'd0, min_smp});
    write_reg(tpsl_pkg::CFG_WALK_CLASS_LIMIT, {13'd0, walk});
    write_reg(tpsl_pkg::CFG_LENGTH_GAIN, {8'd0, gain});
    cfg_we_i <= 1'b0;
  endtask

  // A sample that should not complete a step: low magnitude or a non-walking class.
  task automatic pick_quiet(output logic [15:0] mag, output logic [2:0] cls);
    if (cfg_walk_limit != 3'd7 && (cfg_threshold == 16'd0 || $urandom_range(0, 1) == 0)) begin
      mag = 16'($urandom);
      cls = 3'($urandom_range(cfg_walk_limit + 1, 7));
    end else begin
      mag = 16'($urandom_range(0, cfg_threshold));
      cls = 3'($urandom);
    end
  endtask

  // Closing sample of a window, now and then just off the boundary.
  task automatic pick_stride(output logic [15:0] mag, output logic [2:0] cls);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (cfg_threshold == 16'hffff) mag = 16'hffff;
    else if (r == 0) mag = cfg_threshold + 16'd1;
    else mag = 16'($urandom_range(cfg_threshold + 1, 65535));
    cls = 3'($urandom_range(0, cfg_walk_limit));
    if (r == 1) mag = cfg_threshold;
    if (r == 2 && cfg_walk_limit != 3'd7) cls = cfg_walk_limit + 3'd1;
  endtask

  // Windows of quiet samples closed by a stride, mixed with plain noise.
  task automatic run_walk_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned pre;
    logic [15:0] mag;
    logic [2:0]  cls;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        pre = cfg_min_samples + $urandom_range(0, 3);
        repeat (pre) begin
          pick_quiet(mag, cls);
          send_sample(mag, cls, 1'b0, NoStepYet);
        end
        pick_stride(mag, cls);
        send_sample(mag, cls, 1'b0, NoStepYet);
        sent += pre + 1;
      end else begin
        mag = 16'($urandom);
        cls = 3'($urandom);
        send_sample(mag, cls, 1'b0, NoStepYet);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] mag;
    logic [2:0]  cls;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = tpsl_pkg::CFG_STEP_THRESHOLD;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    drv_typed     = 1'b0;
    drv_typed_res = '0;
    pace_gaps     = 1'b1;
    samples_sent  = 0;
    results_seen  = 0;
    mismatches    = 0;
    cycle_cnt     = 0;
    cfg_threshold   = tpsl_pkg::ThreshRst;
    cfg_min_samples = tpsl_pkg::MinSmpRst;
    cfg_walk_limit  = tpsl_pkg::WalkLimRst;
    cfg_gain        = tpsl_pkg::GainRst;
    clear_trackers();
    pred_steps = '0;
    length_sum = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i])
      send_sample(DirectedRows[i].mag, DirectedRows[i].cls, DirectedRows[i].typed,
                  DirectedRows[i].want);

    // Extremes of every register.
    set_config(16'd0, 8'd0, 3'd7, 8'd255);
    run_walk_phase(60);
    set_config(16'hffff, 8'd0, 3'd7, 8'd1);
    run_walk_phase(40);
    set_config(16'($urandom_range(8000, 40000)), 8'd255, 3'd0, 8'd0);
    run_walk_phase(200);

    repeat (6) begin
      set_config(16'($urandom), 8'($urandom_range(0, 20)), 3'($urandom), 8'($urandom));
      pace_gaps = ($urandom_range(0, 3) != 0);
      run_walk_phase(80);
    end
    pace_gaps = 1'b1;

    // Two-sample windows at full gain: each step after the first adds half the gain.
    set_config(16'h8000, 8'd1, 3'd7, 8'd255);
    repeat (55) begin
      mag = 16'($urandom_range(0, 16'h8000));
      cls = 3'($urandom);
      send_sample(mag, cls, 1'b0, NoStepYet);
      mag = 16'($urandom_range(16'h8001, 16'hffff));
      cls = 3'($urandom);
      send_sample(mag, cls, 1'b0, NoStepYet);
    end
    run_walk_phase(30);

    settle();
    repeat (40) @(posedge clk_i);
    if (due_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", due_results.size());
    end
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
